/* hdl/round_robin_source_mux_core_defines.svh */
// assertion macros shared by the round-robin source mux rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ROUND_ROBIN_SOURCE_MUX_CORE_DEFINES_SVH
`define ROUND_ROBIN_SOURCE_MUX_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRSM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RRSM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rrsm_pkg.sv */
// shared types and constants for the round-robin source mux
// no dependencies
package rrsm_pkg;

  localparam int MASK_W   = 8;
  localparam int DELTA_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int LEVEL_W  = 32;
  localparam int ALEVEL_W = 31;
  localparam int SLOT_W   = 3;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_ATTACH = 2'd2;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 32'sh8000_0000;

  // events from the item stage to the level tracker
  typedef struct packed {
    logic adjust;
    logic take_alert;
    logic grant;
  } lvl_ev_t;

  // level tracker status seen by the item stage
  typedef struct packed {
    logic                pending;
    logic [ALEVEL_W-1:0] level;
  } lvl_st_t;

endpackage

/* hdl/rrsm_if.sv */
// valid/ready channel interfaces for requests and results
// depends on rrsm_pkg for field widths
interface rrsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [rrsm_pkg::MASK_W-1:0]         ready_mask;
  logic [rrsm_pkg::MASK_W-1:0]         ended_mask;
  logic signed [rrsm_pkg::DELTA_W-1:0] level_delta;
  logic [rrsm_pkg::SLOT_W-1:0]         attach_slot;

  modport source (output valid, req_type, ready_mask, ended_mask, level_delta, attach_slot,
                  input ready);
  modport sink (input valid, req_type, ready_mask, ended_mask, level_delta, attach_slot,
                output ready);
endinterface

interface rrsm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          delivered;
  logic                          is_alert;
  logic [rrsm_pkg::ALEVEL_W-1:0] alert_level;
  logic [rrsm_pkg::SLOT_W-1:0]   granted_slot;
  logic [rrsm_pkg::MASK_W-1:0]   active_slots;

  modport source (output valid, delivered, is_alert, alert_level, granted_slot, active_slots,
                  input ready);
  modport sink (input valid, delivered, is_alert, alert_level, granted_slot, active_slots,
                output ready);
endinterface

/* hdl/rrsm_poll.sv */
// rotating-priority pick over the active slots, plus the retire mask
// purely combinational; depends on rrsm_pkg
module rrsm_poll #(
  parameter int SLOTS = 8,
  parameter int PW    = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0]            active,
  input  logic [PW-1:0]               ptr,
  input  logic [rrsm_pkg::MASK_W-1:0] ready_mask,
  input  logic [rrsm_pkg::MASK_W-1:0] ended_mask,
  output logic                        hit,
  output logic [PW-1:0]               grant,
  output logic [SLOTS-1:0]            retire
);

  logic [63:0]      rdy64;
  logic [63:0]      end64;
  logic [SLOTS-1:0] cand;
  logic [SLOTS-1:0] cand_hi;
  logic [SLOTS-1:0] visited;
  logic [PW-1:0]    g_lo;
  logic [PW-1:0]    g_hi;

  // slots past the eighth have no ready or ended bit
  assign rdy64 = 64'(ready_mask);
  assign end64 = 64'(ended_mask);
  assign cand  = active & rdy64[SLOTS-1:0];

  always_comb begin
    cand_hi = '0;
    g_lo    = '0;
    g_hi    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      cand_hi[s] = cand[s] && (PW'(s) >= ptr);
    end
    // descending scan, last match is the lowest index
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (cand[s]) g_lo = PW'(s);
      if (cand_hi[s]) g_hi = PW'(s);
    end
  end

  assign hit   = |cand;
  assign grant = (|cand_hi) ? g_hi : g_lo;

  // polled slots run from the pointer up to the grant, wrapping; every slot when nothing is granted
  always_comb begin
    visited = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit) begin
        visited[s] = 1'b1;
      end else if (grant >= ptr) begin
        visited[s] = (PW'(s) >= ptr) && (PW'(s) <= grant);
      end else begin
        visited[s] = (PW'(s) >= ptr) || (PW'(s) <= grant);
      end
    end
  end

  assign retire = visited & active & end64[SLOTS-1:0];

endmodule

/* hdl/rrsm_level.sv */
// queue-level counter, grant counter and pending alert flag
// holds the alert period register; depends on rrsm_pkg
module rrsm_level (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrsm_pkg::PERIOD_W-1:0]       cfg_wdata,
  input  rrsm_pkg::lvl_ev_t                   ev,
  input  logic signed [rrsm_pkg::DELTA_W-1:0] delta,
  output rrsm_pkg::lvl_st_t                   st
);

  logic [rrsm_pkg::PERIOD_W-1:0]       period;
  logic signed [rrsm_pkg::LEVEL_W-1:0] level;
  logic signed [rrsm_pkg::LEVEL_W-1:0] level_next;
  logic [rrsm_pkg::PERIOD_W-1:0]       grants;
  logic [rrsm_pkg::PERIOD_W-1:0]       grants_next;
  logic                                pending;
  logic                                pending_next;
  logic signed [rrsm_pkg::LEVEL_W:0]   sum;
  logic [rrsm_pkg::PERIOD_W-1:0]       grants_inc;

  assign sum        = (rrsm_pkg::LEVEL_W + 1)'(level) + (rrsm_pkg::LEVEL_W + 1)'(delta);
  assign grants_inc = grants + rrsm_pkg::PERIOD_W'(1);

  always_comb begin
    level_next   = level;
    grants_next  = grants;
    pending_next = pending;
    if (ev.adjust) begin
      // saturate when the carry disagrees with the sign
      if (sum[rrsm_pkg::LEVEL_W] != sum[rrsm_pkg::LEVEL_W-1]) begin
        level_next = sum[rrsm_pkg::LEVEL_W] ? rrsm_pkg::LEVEL_MIN : rrsm_pkg::LEVEL_MAX;
      end else begin
        level_next = sum[rrsm_pkg::LEVEL_W-1:0];
      end
      pending_next = 1'b1;
    end
    if (ev.take_alert) begin
      pending_next = 1'b0;
    end
    if (ev.grant && (period != '0)) begin
      if (level != rrsm_pkg::LEVEL_MIN) level_next = level - rrsm_pkg::LEVEL_W'(1);
      if (grants_inc >= period) begin
        grants_next  = '0;
        pending_next = 1'b1;
      end else begin
        grants_next = grants_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= '0;
      level   <= '0;
      grants  <= '0;
      pending <= 1'b0;
    end else begin
      if (cfg_we) period <= cfg_wdata;
      level   <= level_next;
      grants  <= grants_next;
      pending <= pending_next;
    end
  end

  assign st.pending = pending;
  assign st.level   = level[rrsm_pkg::LEVEL_W-1] ? '0 : level[rrsm_pkg::ALEVEL_W-1:0];

endmodule

/* hdl/round_robin_source_mux_core.sv */
// Round-robin source mux: attach, level-adjust and read requests come in on in_ch, and
// each request yields exactly one result on out_ch. A read returns a pending queue-level
// alert first, otherwise it grants the first ready active slot from the rotating pointer,
// retiring any polled slot flagged ended. The block takes one request per clock while out_ch
// is not held by backpressure, and out_ch.valid rises from the result register once the
// request has passed the input register; in_ch.ready drops only while the result register
// is held by out_ch backpressure. The user must write alert_period through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce it.
// Depends on rrsm_pkg, rrsm_if, rrsm_poll, rrsm_level and the defines header.
`include "round_robin_source_mux_core_defines.svh"

module round_robin_source_mux_core #(
  parameter int SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  rrsm_in_if.sink                       in_ch,
  rrsm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rrsm_pkg::PERIOD_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(SLOTS);

  // input register
  logic                                s1_valid;
  logic [1:0]                          s1_type;
  logic [rrsm_pkg::MASK_W-1:0]         s1_ready;
  logic [rrsm_pkg::MASK_W-1:0]         s1_ended;
  logic signed [rrsm_pkg::DELTA_W-1:0] s1_delta;
  logic [rrsm_pkg::SLOT_W-1:0]         s1_slot;

  // slot state
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] active_next;
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    ptr_next;

  logic                 fire;
  logic                 in_fire;
  logic                 is_read;
  logic                 poll;
  logic                 hit;
  logic [PW-1:0]        grant;
  logic [SLOTS-1:0]     retire;
  logic [SLOTS-1:0]     attach_bit;
  logic [63:0]          act64;
  logic [63:0]          grant64;
  rrsm_pkg::lvl_ev_t    ev;
  rrsm_pkg::lvl_st_t    lvl_st;

  assign fire         = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_read      = (s1_type == rrsm_pkg::REQ_READ);
  assign poll         = is_read && !lvl_st.pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type  <= in_ch.req_type;
      s1_ready <= in_ch.ready_mask;
      s1_ended <= in_ch.ended_mask;
      s1_delta <= in_ch.level_delta;
      s1_slot  <= in_ch.attach_slot;
    end
  end

  rrsm_poll #(
    .SLOTS (SLOTS),
    .PW    (PW)
  ) u_poll (
    .active     (active),
    .ptr        (ptr),
    .ready_mask (s1_ready),
    .ended_mask (s1_ended),
    .hit        (hit),
    .grant      (grant),
    .retire     (retire)
  );

  assign ev.adjust     = fire && (s1_type == rrsm_pkg::REQ_ADJUST);
  assign ev.take_alert = fire && is_read && lvl_st.pending;
  assign ev.grant      = fire && poll && hit;

  rrsm_level u_level (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ev        (ev),
    .delta     (s1_delta),
    .st        (lvl_st)
  );

  always_comb begin
    attach_bit = '0;
    for (int s = 0; s < SLOTS; s++) begin
      attach_bit[s] = (int'(s1_slot) == s);
    end
  end

  always_comb begin
    active_next = active;
    ptr_next    = ptr;
    case (s1_type)
      rrsm_pkg::REQ_ATTACH: active_next = active | attach_bit;
      rrsm_pkg::REQ_READ: begin
        if (!lvl_st.pending) begin
          active_next = active & ~retire;
          if (hit) begin
            ptr_next = (grant == PW'(SLOTS - 1)) ? '0 : grant + PW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      ptr    <= '0;
    end else if (fire) begin
      active <= active_next;
      ptr    <= ptr_next;
    end
  end

  assign act64   = 64'(active_next);
  assign grant64 = 64'(grant);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.delivered    <= ev.take_alert || ev.grant;
      out_ch.is_alert     <= ev.take_alert;
      out_ch.alert_level  <= ev.take_alert ? lvl_st.level : '0;
      out_ch.granted_slot <= ev.grant ? grant64[rrsm_pkg::SLOT_W-1:0] : '0;
      out_ch.active_slots <= act64[rrsm_pkg::MASK_W-1:0];
    end
  end

  `RRSM_ASSERT_NXT(a_ptr_moves_on_grant, clk, rst, !ev.grant, $stable(ptr),
                   "round-robin pointer moved without a grant")

  `RRSM_ASSERT_NXT(a_attach_only_adds, clk, rst,
                   !(fire && (s1_type == rrsm_pkg::REQ_ATTACH)),
                   ((active & ~$past(active)) == '0),
                   "slot became active without an attach")

  `RRSM_ASSERT_NXT(a_alert_consumed, clk, rst, ev.take_alert, !lvl_st.pending,
                   "alert still pending after being delivered")

  `RRSM_ASSERT_IMP(a_grant_in_range, clk, rst,
                   out_ch.valid && out_ch.delivered && !out_ch.is_alert,
                   (int'(out_ch.granted_slot) < SLOTS),
                   "granted slot outside the configured slot count")

endmodule
